>>> hdl/fswc_pkg.sv
`timescale 1ns / 1ps

package fswc_pkg;

  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned STORE_BYTES  = 65536;
  localparam int unsigned SECTOR_AW    = $clog2(SECTOR_BYTES);
  localparam int unsigned STORE_AW     = $clog2(STORE_BYTES);
  localparam int unsigned SECTOR_NW    = STORE_AW - SECTOR_AW;
  localparam int unsigned SECTOR_NUM   = STORE_BYTES / SECTOR_BYTES;
  localparam int unsigned PART_W       = 17;

  localparam logic [7:0]        ERASED_BYTE       = 8'hff;
  localparam logic [PART_W-1:0] GLOBAL_SIZE_RST   = PART_W'(8192);
  localparam logic [PART_W-1:0] ACCOUNTS_SIZE_RST = PART_W'(57344);

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PART_GLOBAL   = 2'd0,
    PART_ACCOUNTS = 2'd1,
    PART_BAD2     = 2'd2,
    PART_BAD3     = 2'd3
  } part_t;

  typedef enum logic [0:0] {
    REG_GLOBAL_SIZE   = 1'b0,
    REG_ACCOUNTS_SIZE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_RDATA,
    S_COPY,
    S_RESP
  } state_t;

endpackage

>>> hdl/flash_sector_write_cache.sv
`timescale 1ns / 1ps
// Read, write hit, invalid and no-op transactions pass through the decode state to the
// result state, a read through the read-data state as well; a write miss or a flush of a
// held sector streams one sector through the cache and store memory ports, one byte a cycle.
// One transaction at a time; the next is taken once the result sits in the output register.
// Reset: synchronous; no clearing pass. One written flag per store sector makes a sector
// never written back read as erased bytes; cache contents matter only while its tag is valid.
module flash_sector_write_cache (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [fswc_pkg::PART_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [1:0]                   partition,
  input  logic [15:0]                  offset,
  input  logic [7:0]                   write_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         status,
  output logic [7:0]                   read_data,
  output logic                         cache_hit,
  output logic                         wrote_back,
  output logic                         loaded_sector
);
  import fswc_pkg::*;

  logic [PART_W-1:0] global_size;
  logic [PART_W-1:0] accounts_size;

  state_t state, state_next;

  mode_t          mode_q;
  part_t          part_q;
  logic [15:0]    off_q;
  logic [7:0]     wdata_q;

  logic [STORE_AW-1:0]  phys_r;
  logic [SECTOR_NW-1:0] cache_tag;
  logic                 cache_valid;
  logic [SECTOR_NUM-1:0] sector_written;

  logic [SECTOR_NW-1:0] wb_sec;
  logic [SECTOR_NW-1:0] ld_sec;
  logic                 do_wb;
  logic                 do_load;
  logic [SECTOR_AW-1:0] cnt;
  logic [SECTOR_AW-1:0] pidx;
  logic                 pend;
  logic                 rd_from_cache;

  logic                 res_status;
  logic [7:0]           res_data;
  logic                 res_hit;
  logic                 res_wb;
  logic                 res_load;

  logic [7:0] cache_mem [SECTOR_BYTES];
  logic [7:0] store_mem [STORE_BYTES];
  logic [7:0] cache_q;
  logic [7:0] store_q;

  // address map, evaluated on the latched request
  logic [PART_W-1:0]   part_size;
  logic [PART_W-1:0]   part_base;
  logic [PART_W:0]     phys_sum;
  logic                addr_ok;
  logic [STORE_AW-1:0] phys;
  logic                hit;
  logic                in_accept;
  logic                out_free;

  logic [SECTOR_AW-1:0] cache_raddr;
  logic [STORE_AW-1:0]  store_raddr;
  logic                 dec_write_hit;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    part_size = accounts_size;
    part_base = global_size;
    if (part_q == PART_GLOBAL) begin
      part_size = global_size;
      part_base = '0;
    end
    phys_sum = {1'b0, part_base} + (PART_W + 1)'(off_q);
    addr_ok  = (part_q == PART_GLOBAL || part_q == PART_ACCOUNTS) &&
               ({1'b0, off_q} < part_size) &&
               (phys_sum < (PART_W + 1)'(STORE_BYTES));
    phys     = phys_sum[STORE_AW-1:0];
    hit      = cache_valid && (phys[STORE_AW-1:SECTOR_AW] == cache_tag);
    dec_write_hit = (state == S_DEC) && (mode_q == MODE_WRITE) && addr_ok && hit;
  end

  always_comb begin
    state_next  = state;
    cache_raddr = phys[SECTOR_AW-1:0];
    store_raddr = phys;
    case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_DEC;
      end
      S_DEC: begin
        if (mode_q == MODE_FLUSH) begin
          state_next = cache_valid ? S_COPY : S_RESP;
        end else if (mode_q == MODE_NOP || !addr_ok) begin
          state_next = S_RESP;
        end else if (mode_q == MODE_READ) begin
          state_next = S_RDATA;
        end else begin
          state_next = hit ? S_RESP : S_COPY;
        end
      end
      S_RDATA: begin
        state_next = S_RESP;
      end
      S_COPY: begin
        cache_raddr = cnt;
        store_raddr = {ld_sec, cnt};
        if (cnt == '1) state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      global_size    <= GLOBAL_SIZE_RST;
      accounts_size  <= ACCOUNTS_SIZE_RST;
      cache_valid    <= 1'b0;
      cache_tag      <= '0;
      sector_written <= '0;
      out_valid      <= 1'b0;
      pend           <= 1'b0;
      cnt            <= '0;
    end else begin
      state <= state_next;
      pend  <= (state == S_COPY);
      if (cfg_we) begin
        if (reg_index_t'(cfg_index) == REG_GLOBAL_SIZE) global_size <= cfg_data;
        else accounts_size <= cfg_data;
      end
      if (state == S_COPY) cnt <= cnt + 1'b1;
      else cnt <= '0;
      if (state == S_DEC) begin
        if (mode_q == MODE_FLUSH) begin
          if (cache_valid) sector_written[cache_tag] <= 1'b1;
          cache_valid <= 1'b0;
          cache_tag   <= '0;
        end else if (mode_q == MODE_WRITE && addr_ok && !hit) begin
          if (cache_valid) sector_written[cache_tag] <= 1'b1;
          cache_valid <= 1'b1;
          cache_tag   <= phys[STORE_AW-1:SECTOR_AW];
        end
      end
      if (state == S_RESP && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q  <= mode_t'(mode);
      part_q  <= part_t'(partition);
      off_q   <= offset;
      wdata_q <= write_data;
    end
    pidx <= cnt;
    if (state == S_DEC) begin
      phys_r        <= phys;
      wb_sec        <= cache_tag;
      ld_sec        <= phys[STORE_AW-1:SECTOR_AW];
      rd_from_cache <= hit;
      do_wb         <= cache_valid;
      do_load       <= (mode_q == MODE_WRITE);
      res_status    <= (mode_q == MODE_READ || mode_q == MODE_WRITE) && !addr_ok;
      res_data      <= '0;
      res_hit       <= (mode_q == MODE_READ || mode_q == MODE_WRITE) && addr_ok && hit;
      res_wb        <= (mode_q == MODE_FLUSH) ? cache_valid :
                       ((mode_q == MODE_WRITE) && addr_ok && !hit && cache_valid);
      res_load      <= (mode_q == MODE_WRITE) && addr_ok && !hit;
    end
    if (state == S_RDATA) begin
      if (rd_from_cache) res_data <= cache_q;
      else if (sector_written[phys_r[STORE_AW-1:SECTOR_AW]]) res_data <= store_q;
      else res_data <= ERASED_BYTE;
    end
    if (state == S_RESP && out_free) begin
      status        <= res_status;
      read_data     <= res_data;
      cache_hit     <= res_hit;
      wrote_back    <= res_wb;
      loaded_sector <= res_load;
    end
  end

  // cache memory: one read, one write per cycle
  always_ff @(posedge clk) begin
    cache_q <= cache_mem[cache_raddr];
    if (pend && do_load) begin
      if (pidx == phys_r[SECTOR_AW-1:0]) cache_mem[pidx] <= wdata_q;
      else if (sector_written[ld_sec]) cache_mem[pidx] <= store_q;
      else cache_mem[pidx] <= ERASED_BYTE;
    end else if (dec_write_hit) begin
      cache_mem[phys[SECTOR_AW-1:0]] <= wdata_q;
    end
  end

  // store memory: the old sector is written back while the new one is read
  always_ff @(posedge clk) begin
    store_q <= store_mem[store_raddr];
    if (pend && do_wb) store_mem[{wb_sec, pidx}] <= cache_q;
  end

  a_copy_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> (do_wb || do_load))
    else $error("sector copy with nothing to move");

  a_swap_distinct: assert property (@(posedge clk) disable iff (rst)
    (pend && do_wb && do_load) |-> (wb_sec != ld_sec))
    else $error("write-back and load target the same sector");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_DEC))
    else $error("accepted transaction not decoded");

  a_copy_cache_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && do_load) |-> (cache_valid && cache_tag == ld_sec))
    else $error("loading sector does not match cache tag");

endmodule

>>> tb/tb_flash_sector_write_cache.sv
`timescale 1ns / 1ps

module tb_flash_sector_write_cache;
  import fswc_pkg::*;

  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
    logic       cache_hit;
    logic       wrote_back;
    logic       loaded_sector;
  } cache_result_t;

  // Tracks store and cached sector contents, and queues the expected result per transaction.
  class cache_scoreboard;
    bit [7:0]          store_mem [STORE_BYTES];
    bit [7:0]          line_mem [SECTOR_BYTES];
    bit                line_valid;
    int unsigned       line_tag;
    logic [PART_W-1:0] global_size;
    logic [PART_W-1:0] accounts_size;
    cache_result_t     expected_q [$];
    int                errors;
    int                results_seen;

    function new();
      foreach (store_mem[i]) store_mem[i] = ERASED_BYTE;
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      line_valid    = 1'b0;
      line_tag      = 0;
      global_size   = GLOBAL_SIZE_RST;
      accounts_size = ACCOUNTS_SIZE_RST;
      errors        = 0;
      results_seen  = 0;
    endfunction

    function void set_sizes(logic [PART_W-1:0] gsize, logic [PART_W-1:0] asize);
      global_size   = gsize;
      accounts_size = asize;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_line_back();
      foreach (line_mem[i]) store_mem[line_tag + i] = line_mem[i];
    endfunction

    function void note_input(mode_t m, part_t p, logic [15:0] off, logic [7:0] d);
      cache_result_t r;
      int unsigned   base;
      int unsigned   span;
      int unsigned   phys;
      int unsigned   tag;
      bit            ok;
      bit            hit;
      r    = '0;
      ok   = 1'b1;
      base = 0;
      span = 0;
      if (m == MODE_FLUSH) begin
        if (line_valid) begin
          write_line_back();
          r.wrote_back = 1'b1;
        end
        line_valid = 1'b0;
        line_tag   = 0;
        foreach (line_mem[i]) line_mem[i] = 8'h00;
      end else if (m != MODE_NOP) begin
        case (p)
          PART_GLOBAL: begin
            span = global_size;
          end
          PART_ACCOUNTS: begin
            span = accounts_size;
            base = global_size;
          end
          default: begin
            ok = 1'b0;
          end
        endcase
        phys = off + base;
        if (!ok || off >= span || phys >= STORE_BYTES) begin
          r.status = 1'b1;
        end else begin
          tag = phys - phys % SECTOR_BYTES;
          hit = line_valid && tag == line_tag;
          if (m == MODE_READ) begin
            r.read_data = hit ? line_mem[phys - tag] : store_mem[phys];
            r.cache_hit = hit;
          end else begin
            if (hit) begin
              r.cache_hit = 1'b1;
            end else begin
              if (line_valid) begin
                write_line_back();
                r.wrote_back = 1'b1;
              end
              foreach (line_mem[i]) line_mem[i] = store_mem[tag + i];
              line_tag        = tag;
              line_valid      = 1'b1;
              r.loaded_sector = 1'b1;
            end
            line_mem[phys - tag] = d;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("ERROR [%0t] result %0d: %s", $time, results_seen, msg);
    endtask

    task check_result(logic st, logic [7:0] rd, logic hit, logic wb, logic ld);
      cache_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result status=%0b read_data=%02h", st, rd));
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status)
        report($sformatf("status got %0b want %0b", st, want.status));
      if (rd !== want.read_data)
        report($sformatf("read_data got %02h want %02h", rd, want.read_data));
      if (hit !== want.cache_hit)
        report($sformatf("cache_hit got %0b want %0b", hit, want.cache_hit));
      if (wb !== want.wrote_back)
        report($sformatf("wrote_back got %0b want %0b", wb, want.wrote_back));
      if (ld !== want.loaded_sector)
        report($sformatf("loaded_sector got %0b want %0b", ld, want.loaded_sector));
    endtask
  endclass

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = 1'b0;
  logic [PART_W-1:0] cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [1:0]        mode       = '0;
  logic [1:0]        partition  = '0;
  logic [15:0]       offset     = '0;
  logic [7:0]        write_data = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic              status;
  logic [7:0]        read_data;
  logic              cache_hit;
  logic              wrote_back;
  logic              loaded_sector;

  cache_scoreboard   sb = new();
  int                sent = 0;
  int                burst_left = 0;
  bit                hold_request = 1'b0;
  logic [PART_W-1:0] g_size = GLOBAL_SIZE_RST;
  logic [PART_W-1:0] a_size = ACCOUNTS_SIZE_RST;
  int unsigned       recent_phys [$];

  flash_sector_write_cache DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, read_data, cache_hit, wrote_back, loaded_sector);
  end

  // Receiver: stall stretches of varying density, plus one long hold on request.
  initial begin
    int span;
    int pct;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span = $urandom_range(10, 60);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 30;
          2: pct = 75;
          default: pct = 50;
        endcase
        repeat (span) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  // Called at a clock edge; returns at the edge where the transaction is taken.
  task automatic send_txn(mode_t m, part_t p, logic [15:0] off, logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    mode       <= m;
    partition  <= p;
    offset     <= off;
    write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(m, p, off, d);
    sent++;
  endtask

  task automatic send_noise();
    send_txn(mode_t'($urandom_range(0, 3)), part_t'($urandom_range(0, 3)),
             16'($urandom), 8'($urandom));
  endtask

  function automatic bit map_phys(int unsigned phys, output part_t p, output logic [15:0] off);
    p   = PART_GLOBAL;
    off = '0;
    if (phys >= STORE_BYTES) return 1'b0;
    if (phys < g_size) begin
      off = 16'(phys);
      return 1'b1;
    end
    if (phys - g_size < a_size) begin
      p   = PART_ACCOUNTS;
      off = 16'(phys - g_size);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Reads, writes, flushes and no-ops clustered in one sector, sometimes one seen before.
  task automatic run_sequence();
    int unsigned center;
    int unsigned sect;
    int unsigned phys;
    int          n;
    int          tries;
    int          r;
    part_t       p;
    logic [15:0] off;
    mode_t       m;
    bit          found;
    found = 1'b0;
    if (recent_phys.size() > 0 && $urandom_range(0, 1) == 1) begin
      center = recent_phys[$urandom_range(0, recent_phys.size() - 1)];
      found  = map_phys(center, p, off);
    end
    for (tries = 0; tries < 64 && !found; tries++) begin
      center = $urandom_range(0, STORE_BYTES - 1);
      found  = map_phys(center, p, off);
    end
    if (!found) begin
      send_noise();
      return;
    end
    recent_phys.push_back(center);
    if (recent_phys.size() > 8) void'(recent_phys.pop_front());
    sect  = center - center % SECTOR_BYTES;
    n     = $urandom_range(6, 24);
    tries = 0;
    while (n > 0 && tries < 200) begin
      tries++;
      if ($urandom_range(0, 3) == 0)
        phys = sect + $urandom_range(0, SECTOR_BYTES - 1);
      else
        phys = sect + (center % SECTOR_BYTES + $urandom_range(0, 15)) % SECTOR_BYTES;
      if (map_phys(phys, p, off)) begin
        r = $urandom_range(0, 99);
        m = (r < 45) ? MODE_WRITE : (r < 94) ? MODE_READ : (r < 97) ? MODE_FLUSH : MODE_NOP;
        send_txn(m, p, off, 8'($urandom));
        n--;
      end
    end
  endtask

  task automatic run_random(int count);
    int target;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0)
        send_noise();
      else
        run_sequence();
    end
  endtask

  task automatic write_sizes(logic [PART_W-1:0] gsize, logic [PART_W-1:0] asize);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GLOBAL_SIZE;
    cfg_data  <= gsize;
    @(posedge clk);
    cfg_index <= REG_ACCOUNTS_SIZE;
    cfg_data  <= asize;
    @(posedge clk);
    cfg_we <= 1'b0;
    g_size = gsize;
    a_size = asize;
    sb.set_sizes(gsize, asize);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed transactions at the reset partition sizes
    send_txn(MODE_READ,  PART_GLOBAL,   16'd0,     8'h00);
    send_txn(MODE_WRITE, PART_GLOBAL,   16'd0,     8'h00);
    send_txn(MODE_WRITE, PART_GLOBAL,   16'd4095,  8'hff);
    send_txn(MODE_READ,  PART_GLOBAL,   16'd0,     8'hff);
    send_txn(MODE_READ,  PART_GLOBAL,   16'd4095,  8'h00);
    send_txn(MODE_WRITE, PART_ACCOUNTS, 16'd0,     8'ha5);
    send_txn(MODE_READ,  PART_GLOBAL,   16'd0,     8'h00);
    send_txn(MODE_READ,  PART_ACCOUNTS, 16'd0,     8'h00);
    send_txn(MODE_READ,  PART_ACCOUNTS, 16'd57343, 8'h00);
    send_txn(MODE_WRITE, PART_ACCOUNTS, 16'd57343, 8'h5a);
    send_txn(MODE_READ,  PART_ACCOUNTS, 16'd57344, 8'h00);
    send_txn(MODE_WRITE, PART_GLOBAL,   16'd8192,  8'h11);
    send_txn(MODE_READ,  PART_GLOBAL,   16'd65535, 8'h00);
    send_txn(MODE_READ,  PART_BAD2,     16'd0,     8'h00);
    send_txn(MODE_WRITE, PART_BAD3,     16'd65535, 8'hff);
    send_txn(MODE_NOP,   PART_BAD3,     16'hffff,  8'hff);
    send_txn(MODE_FLUSH, PART_BAD2,     16'h1234,  8'h77);
    send_txn(MODE_FLUSH, PART_GLOBAL,   16'd0,     8'h00);
    send_txn(MODE_READ,  PART_ACCOUNTS, 16'd57343, 8'h00);
    send_txn(MODE_READ,  PART_GLOBAL,   16'd0,     8'h00);
    send_txn(MODE_NOP,   PART_GLOBAL,   16'd0,     8'h00);

    hold_request = 1'b1;
    run_random(105);
    write_sizes(PART_W'(0), PART_W'(65536));
    run_random(105);
    write_sizes(PART_W'(65536), PART_W'(0));
    run_random(105);
    // sizes sum past the end of the store
    write_sizes(PART_W'(40000), PART_W'(65536));
    run_random(105);
    write_sizes(PART_W'(131071), PART_W'(131071));
    run_random(105);
    write_sizes(PART_W'(4096), PART_W'(4096));
    run_random(105);
    write_sizes(PART_W'($urandom_range(0, 65536)), PART_W'($urandom_range(0, 65536)));
    run_random(105);
    write_sizes(PART_W'(12288), PART_W'(53248));
    run_random(105);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SECTOR_BYTES + 16) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #250ms;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hdl/fswc_pkg.sv
hdl/flash_sector_write_cache.sv
tb/tb_flash_sector_write_cache.sv
